[rtl/core/sfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared types and constants for the struct member layout core.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int BYTES_W        = 16;
  localparam int FIELD_W        = 7;
  localparam int SHIFT_W        = 19;
  localparam int MASK_W         = 64;
  localparam int ALIGN_W        = 3;
  localparam int BITS_PER_BYTE  = 8;

  // largest alignment is 16 bytes
  localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 3'd4;

  // one member request as it sits in the input register
  typedef struct packed {
    logic [BYTES_W-1:0] member_bytes;
    logic [FIELD_W-1:0] field_bits;
    logic               final_member;
  } item_t;

  // low ones for a bit-field; a width of MASK_W or more gives all ones
  function automatic logic [MASK_W-1:0] field_mask(input logic [FIELD_W-1:0] bits);
    logic [MASK_W-1:0] m;
    if (bits >= FIELD_W'(MASK_W)) begin
      m = '1;
    end else begin
      m = (MASK_W'(1) << bits) - MASK_W'(1);
    end
    return m;
  endfunction

endpackage

[rtl/core/sfl_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_in_stage
// Input register: takes one request, holds it until the layout stage moves it.
// ----------------------------------------------------------------------------
module sfl_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfl_pkg::BYTES_W-1:0]   member_bytes,
  input  logic [sfl_pkg::FIELD_W-1:0]   field_bits,
  input  logic                          final_member,
  input  logic                          advance,
  output logic                          item_valid,
  output sfl_pkg::item_t                item
);

  logic accept;
  logic item_valid_next;

  // stall only while a held request cannot move on
  assign in_stall = item_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end else begin
      item_valid_next = item_valid;
    end
  end

  // hold the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  // capture the payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item.member_bytes <= member_bytes;
      item.field_bits   <= field_bits;
      item.final_member <= final_member;
    end
  end

endmodule

[rtl/core/sfl_layout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_layout
// Layout state and placement logic: aligns, packs bit-fields and saturates.
// ----------------------------------------------------------------------------
module sfl_layout #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sfl_pkg::ALIGN_W-1:0]       cfg_data,
  input  logic                              fire,
  input  sfl_pkg::item_t                    item,
  output logic [OFFSET_BITS-1:0]            res_offset,
  output logic [sfl_pkg::SHIFT_W-1:0]       res_shift,
  output logic [sfl_pkg::MASK_W-1:0]        res_mask,
  output logic [OFFSET_BITS-1:0]            res_struct_bytes,
  output logic                              res_final,
  output logic                              res_overflow
);

  localparam int SUM_W = ((OFFSET_BITS > sfl_pkg::BYTES_W) ? OFFSET_BITS
                                                           : sfl_pkg::BYTES_W) + 1;
  localparam logic [OFFSET_BITS-1:0] TOTAL_MAX = '1;

  // layout state
  logic [sfl_pkg::ALIGN_W-1:0]  align_log2;
  logic [OFFSET_BITS-1:0]       running_total;
  logic [sfl_pkg::BYTES_W-1:0]  unit_bytes;
  logic [sfl_pkg::SHIFT_W-1:0]  unit_bits_used;
  logic [OFFSET_BITS-1:0]       unit_start;
  logic                         overflow_seen;

  logic [sfl_pkg::ALIGN_W-1:0]  lg;
  logic [sfl_pkg::SHIFT_W-1:0]  cap;
  logic [sfl_pkg::SHIFT_W:0]    used_sum;
  logic [sfl_pkg::SHIFT_W:0]    used_new;
  logic                         is_field;
  logic                         fresh;
  logic                         place;
  logic                         unit_full;
  logic [OFFSET_BITS:0]         round1;
  logic                         a_ovf;
  logic [OFFSET_BITS-1:0]       aligned;
  logic [SUM_W-1:0]             sum;
  logic                         s_ovf;
  logic [OFFSET_BITS-1:0]       added;
  logic [OFFSET_BITS-1:0]       total_next;
  logic [OFFSET_BITS:0]         round2;
  logic                         overflow_now;

  // round up to the alignment; the carry bit flags overflow
  function automatic logic [OFFSET_BITS:0] round_up(input logic [OFFSET_BITS-1:0] t,
                                                    input logic [sfl_pkg::ALIGN_W-1:0] l);
    logic [OFFSET_BITS:0] am;
    am = ((OFFSET_BITS+1)'(1) << l) - (OFFSET_BITS+1)'(1);
    return ({1'b0, t} + am) & ~am;
  endfunction

  // clamp out-of-range alignment
  assign lg = (align_log2 > sfl_pkg::MAX_ALIGN_LOG2) ? sfl_pkg::MAX_ALIGN_LOG2 : align_log2;

  // decide whether a new storage unit opens
  assign is_field = (item.field_bits != '0);
  assign cap      = {item.member_bytes, 3'b000};
  assign used_sum = {1'b0, unit_bits_used} + (sfl_pkg::SHIFT_W+1)'(item.field_bits);
  assign fresh    = (unit_bits_used == '0) || (unit_bytes != item.member_bytes) ||
                    (used_sum > {1'b0, cap});
  assign place    = !is_field || fresh;
  assign used_new = fresh ? (sfl_pkg::SHIFT_W+1)'(item.field_bits) : used_sum;
  assign unit_full = (used_new >= {1'b0, cap});

  // align the running total, then add the member size
  assign round1  = round_up(running_total, lg);
  assign a_ovf   = round1[OFFSET_BITS];
  assign aligned = a_ovf ? TOTAL_MAX : round1[OFFSET_BITS-1:0];

  assign sum     = SUM_W'(aligned) + SUM_W'(item.member_bytes);
  assign s_ovf   = (sum[SUM_W-1:OFFSET_BITS] != '0);
  assign added   = s_ovf ? TOTAL_MAX : sum[OFFSET_BITS-1:0];

  assign total_next = place ? added : running_total;

  // padded struct size on the last member
  assign round2 = round_up(total_next, lg);

  assign overflow_now = overflow_seen || (place && (a_ovf || s_ovf)) ||
                        (item.final_member && round2[OFFSET_BITS]);

  // result of this member
  assign res_offset = place ? aligned : unit_start;
  assign res_shift  = (is_field && !fresh) ? unit_bits_used : '0;
  assign res_mask   = is_field ? sfl_pkg::field_mask(item.field_bits) : '0;
  assign res_final  = item.final_member;
  assign res_overflow = overflow_now;

  always_comb begin
    if (!item.final_member) begin
      res_struct_bytes = '0;
    end else if (round2[OFFSET_BITS]) begin
      res_struct_bytes = TOTAL_MAX;
    end else begin
      res_struct_bytes = round2[OFFSET_BITS-1:0];
    end
  end

  // alignment register
  always_ff @(posedge clk) begin
    if (rst) begin
      align_log2 <= '0;
    end else if (cfg_write) begin
      align_log2 <= cfg_data;
    end
  end

  // advance the layout state; drop it after the last member
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total  <= '0;
      unit_bytes     <= '0;
      unit_bits_used <= '0;
      unit_start     <= '0;
      overflow_seen  <= 1'b0;
    end else if (fire) begin
      if (item.final_member) begin
        running_total  <= '0;
        unit_bytes     <= '0;
        unit_bits_used <= '0;
        unit_start     <= '0;
        overflow_seen  <= 1'b0;
      end else begin
        running_total <= total_next;
        overflow_seen <= overflow_now;
        if (is_field && fresh) begin
          unit_start <= aligned;
        end
        if (!is_field || unit_full) begin
          unit_bytes     <= '0;
          unit_bits_used <= '0;
        end else begin
          unit_bytes     <= item.member_bytes;
          unit_bits_used <= used_new[sfl_pkg::SHIFT_W-1:0];
        end
      end
    end
  end

endmodule

[rtl/core/sfl_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module sfl_out_stage #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  output logic                          advance,
  input  logic [OFFSET_BITS-1:0]        res_offset,
  input  logic [sfl_pkg::SHIFT_W-1:0]   res_shift,
  input  logic [sfl_pkg::MASK_W-1:0]    res_mask,
  input  logic [OFFSET_BITS-1:0]        res_struct_bytes,
  input  logic                          res_final,
  input  logic                          res_overflow,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OFFSET_BITS-1:0]        byte_offset,
  output logic [sfl_pkg::SHIFT_W-1:0]   bit_shift,
  output logic [sfl_pkg::MASK_W-1:0]    bit_mask,
  output logic [OFFSET_BITS-1:0]        struct_bytes,
  output logic                          is_final,
  output logic                          size_overflow
);

  logic out_valid_next;

  // free to take a new result when empty or being emptied
  assign advance = !out_valid || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (advance) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // capture the result
  always_ff @(posedge clk) begin
    if (load) begin
      byte_offset   <= res_offset;
      bit_shift     <= res_shift;
      bit_mask      <= res_mask;
      struct_bytes  <= res_struct_bytes;
      is_final      <= res_final;
      size_overflow <= res_overflow;
    end
  end

endmodule

[rtl/core/struct_field_layout_core.sv]
`timescale 1ns / 1ps
// Path: an accepted request goes from the input reg through layout into the result reg.
// Throughput: one member per cycle while out_stall is low; the layout state updates in a single pass.
// Cycle time is set by the align / add / align chain on the running total.
// Reset clears the layout state, alignment (to 1 byte) and both valid flags.
// ----------------------------------------------------------------------------
// struct_field_layout_core
// Assigns byte offsets and bit-field positions to struct members in order.
// ----------------------------------------------------------------------------
module struct_field_layout_core #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfl_pkg::ALIGN_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfl_pkg::BYTES_W-1:0]   member_bytes,
  input  logic [sfl_pkg::FIELD_W-1:0]   field_bits,
  input  logic                          final_member,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OFFSET_BITS-1:0]        byte_offset,
  output logic [sfl_pkg::SHIFT_W-1:0]   bit_shift,
  output logic [sfl_pkg::MASK_W-1:0]    bit_mask,
  output logic [OFFSET_BITS-1:0]        struct_bytes,
  output logic                          is_final,
  output logic                          size_overflow
);

  logic                         advance;
  logic                         item_valid;
  logic                         fire;
  sfl_pkg::item_t               item;
  logic [OFFSET_BITS-1:0]       res_offset;
  logic [sfl_pkg::SHIFT_W-1:0]  res_shift;
  logic [sfl_pkg::MASK_W-1:0]   res_mask;
  logic [OFFSET_BITS-1:0]       res_struct_bytes;
  logic                         res_final;
  logic                         res_overflow;

  // move a held request through layout into the result register
  assign fire = item_valid && advance;

  sfl_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .member_bytes (member_bytes),
    .field_bits   (field_bits),
    .final_member (final_member),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  sfl_layout #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_layout (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .fire             (fire),
    .item             (item),
    .res_offset       (res_offset),
    .res_shift        (res_shift),
    .res_mask         (res_mask),
    .res_struct_bytes (res_struct_bytes),
    .res_final        (res_final),
    .res_overflow     (res_overflow)
  );

  sfl_out_stage #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_out (
    .clk              (clk),
    .rst              (rst),
    .load             (fire),
    .advance          (advance),
    .res_offset       (res_offset),
    .res_shift        (res_shift),
    .res_mask         (res_mask),
    .res_struct_bytes (res_struct_bytes),
    .res_final        (res_final),
    .res_overflow     (res_overflow),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .byte_offset      (byte_offset),
    .bit_shift        (bit_shift),
    .bit_mask         (bit_mask),
    .struct_bytes     (struct_bytes),
    .is_final         (is_final),
    .size_overflow    (size_overflow)
  );

endmodule
